// ----- hdl/asfr_pkg.sv -----
// Package: shared types, constants and helpers for the addressed serial frame receiver.
package asfr_pkg;

    localparam int DEFAULT_FRAME_DEPTH = 32;
    localparam int RESP_LEN            = 5;
    localparam int RESP_IDX_W          = 3;
    localparam int CFG_INDEX_W         = 3;
    localparam int CFG_DATA_W          = 16;
    localparam int QUEUE_DEPTH         = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_RX_START   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RX_END     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TX_START   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TX_END     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDR   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CHECK_MODE = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_ERR_CODES  = 3'd7;

    // Input item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Result item kinds
    localparam logic KIND_PAYLOAD  = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

    localparam logic CHECK_SUM = 1'b0;
    localparam logic CHECK_XOR = 1'b1;

    typedef struct packed {
        logic [7:0]  rx_start_byte;
        logic [7:0]  rx_end_byte;
        logic [7:0]  tx_start_byte;
        logic [7:0]  tx_end_byte;
        logic [7:0]  own_address;
        logic        check_mode;
        logic [7:0]  timeout_ticks;
        logic [15:0] error_codes;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        rx_start_byte: 8'd2,
        rx_end_byte:   8'd3,
        tx_start_byte: 8'd2,
        tx_end_byte:   8'd3,
        own_address:   8'd1,
        check_mode:    CHECK_SUM,
        timeout_ticks: 8'd5,
        error_codes:   16'd513
    };

    // Command from front to back: error response with a code, or payload release
    // up to a last RAM index.
    typedef struct packed {
        logic       is_resp;
        logic [7:0] arg;
    } cmd_t;

    function automatic logic [7:0] fold(input logic mode, input logic [7:0] acc,
                                        input logic [7:0] b);
        return (mode == CHECK_XOR) ? (acc ^ b) : (acc + b);
    endfunction

    function automatic logic [7:0] resp_byte(input logic [RESP_IDX_W-1:0] idx,
                                             input cfg_t cfg, input logic [7:0] code);
        logic [7:0] res;
        unique case (idx)
            3'd0:    res = cfg.tx_start_byte;
            3'd1:    res = cfg.own_address;
            3'd2:    res = code;
            3'd3:    res = fold(cfg.check_mode, cfg.own_address, code);
            default: res = cfg.tx_end_byte;
        endcase
        return res;
    endfunction

endpackage

// ----- hdl/asfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module asfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// ----- hdl/asfr_cmd_fifo.sv -----
// Short command queue between the frame front end and the output sequencer.
module asfr_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  asfr_pkg::cmd_t push_data,
    input  logic          pop,
    output asfr_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);
    import asfr_pkg::*;

    cmd_t       entry_reg [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'(QUEUE_DEPTH));
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop && !empty) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if ((push && !full) && !(pop && !empty)) begin
            count_next = count_reg + 2'd1;
        end else if (!(push && !full) && (pop && !empty)) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

// ----- hdl/asfr_front.sv -----
// Front end: frame parser, timeout, block check and frame buffer writes.
module asfr_front #(
    parameter int FRAME_DEPTH = asfr_pkg::DEFAULT_FRAME_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  asfr_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_op,
    input  logic [7:0]                     in_byte,
    input  logic                           back_busy,
    output logic                           ram_wr_en,
    output logic [$clog2(FRAME_DEPTH)-1:0] ram_wr_addr,
    output logic [7:0]                     ram_wr_data,
    output logic                           q_push,
    output asfr_pkg::cmd_t                 q_data,
    input  logic                           q_full
);
    import asfr_pkg::*;

    localparam int COUNT_W = $clog2(FRAME_DEPTH);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_ADDR    = 3'b010,
        PH_COLLECT = 3'b100
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         chk_reg, chk_next;
    logic [7:0]         ticks_reg, ticks_next;
    logic [7:0]         addr_reg, addr_next;
    logic [7:0]         last_reg, last_next;
    logic               take;

    // Buffer must not be refilled while an earlier command may still read it.
    assign in_ready = !q_full && !((phase_reg == PH_COLLECT) && back_busy);
    assign take     = in_valid && in_ready;

    assign ram_wr_addr = count_reg;
    assign ram_wr_data = in_byte;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        chk_next   = chk_reg;
        ticks_next = ticks_reg;
        addr_next  = addr_reg;
        last_next  = last_reg;
        ram_wr_en  = 1'b0;
        q_push     = 1'b0;
        q_data     = '{is_resp: 1'b0, arg: 8'd0};
        if (take) begin
            if (in_op == OP_TICK) begin
                if (phase_reg != PH_IDLE) begin
                    if (ticks_reg <= 8'd1) begin
                        phase_next = PH_IDLE;
                        count_next = '0;
                        chk_next   = 8'd0;
                        ticks_next = cfg.timeout_ticks;
                    end else begin
                        ticks_next = ticks_reg - 8'd1;
                    end
                end
            end else begin
                unique case (phase_reg)
                    PH_IDLE: begin
                        if (in_byte == cfg.rx_start_byte) begin
                            phase_next = PH_ADDR;
                            count_next = '0;
                            chk_next   = 8'd0;
                            ticks_next = cfg.timeout_ticks;
                        end
                    end
                    PH_ADDR: begin
                        if (in_byte != cfg.own_address) begin
                            phase_next = PH_IDLE;
                            count_next = '0;
                            chk_next   = 8'd0;
                            ticks_next = cfg.timeout_ticks;
                        end else begin
                            phase_next = PH_COLLECT;
                            addr_next  = in_byte;
                            last_next  = in_byte;
                            count_next = COUNT_W'(1);
                            chk_next   = 8'd0;
                        end
                    end
                    PH_COLLECT: begin
                        if (in_byte == cfg.rx_end_byte) begin
                            phase_next = PH_IDLE;
                            count_next = '0;
                            chk_next   = 8'd0;
                            ticks_next = cfg.timeout_ticks;
                            if (addr_reg == cfg.own_address) begin
                                if (last_reg != chk_reg) begin
                                    q_push = 1'b1;
                                    q_data = '{is_resp: 1'b1, arg: cfg.error_codes[7:0]};
                                end else if (count_reg > COUNT_W'(2)) begin
                                    // payload sits at indexes 1 .. count-2
                                    q_push = 1'b1;
                                    q_data = '{is_resp: 1'b0,
                                               arg: 8'(count_reg - COUNT_W'(2))};
                                end
                            end
                        end else begin
                            ram_wr_en  = 1'b1;
                            chk_next   = fold(cfg.check_mode, chk_reg, last_reg);
                            last_next  = in_byte;
                            count_next = count_reg + COUNT_W'(1);
                            if (count_reg == COUNT_W'(FRAME_DEPTH - 1)) begin
                                phase_next = PH_IDLE;
                                count_next = '0;
                                chk_next   = 8'd0;
                                ticks_next = cfg.timeout_ticks;
                                q_push     = 1'b1;
                                q_data     = '{is_resp: 1'b1, arg: cfg.error_codes[15:8]};
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            chk_reg   <= 8'd0;
            ticks_reg <= CFG_RESET.timeout_ticks;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            chk_reg   <= chk_next;
            ticks_reg <= ticks_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        last_reg <= last_next;
    end
endmodule

// ----- hdl/asfr_back.sv -----
// Back end: runs queued commands, drains payload or emits error responses.
module asfr_back #(
    parameter int FRAME_DEPTH = asfr_pkg::DEFAULT_FRAME_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  asfr_pkg::cfg_t                 cfg,
    input  asfr_pkg::cmd_t                 q_data,
    input  logic                           q_empty,
    output logic                           q_pop,
    output logic                           busy,
    output logic                           ram_rd_en,
    output logic [$clog2(FRAME_DEPTH)-1:0] ram_rd_addr,
    input  logic [7:0]                     ram_rd_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_kind,
    output logic [7:0]                     out_byte,
    output logic                           out_last
);
    import asfr_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_DEPTH);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_FETCH = 4'b0010,
        B_LOAD  = 4'b0100,
        B_RESP  = 4'b1000
    } bstate_t;

    bstate_t               state_reg, state_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [ADDR_W-1:0]     end_reg, end_next;
    logic [7:0]            code_reg, code_next;
    logic [RESP_IDX_W-1:0] idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic                  kind_reg, kind_next;
    logic [7:0]            byte_reg, byte_next;
    logic                  last_reg, last_next;
    logic                  out_free;

    assign out_free    = !valid_reg || out_ready;
    assign busy        = (state_reg != B_IDLE);
    assign ram_rd_addr = addr_reg;
    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_byte    = byte_reg;
    assign out_last    = last_reg;

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        end_next   = end_reg;
        code_next  = code_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        ram_rd_en  = 1'b0;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop = 1'b1;
                    if (q_data.is_resp) begin
                        code_next  = q_data.arg;
                        idx_next   = '0;
                        state_next = B_RESP;
                    end else begin
                        addr_next  = ADDR_W'(1);
                        end_next   = q_data.arg[ADDR_W-1:0];
                        state_next = B_FETCH;
                    end
                end
            end
            B_FETCH: begin
                ram_rd_en  = 1'b1;
                state_next = B_LOAD;
            end
            B_LOAD: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    kind_next  = KIND_PAYLOAD;
                    byte_next  = ram_rd_data;
                    last_next  = (addr_reg == end_reg);
                    if (addr_reg == end_reg) begin
                        state_next = B_IDLE;
                    end else begin
                        addr_next  = addr_reg + ADDR_W'(1);
                        state_next = B_FETCH;
                    end
                end
            end
            B_RESP: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    kind_next  = KIND_RESPONSE;
                    byte_next  = resp_byte(idx_reg, cfg, code_reg);
                    last_next  = (idx_reg == RESP_IDX_W'(RESP_LEN - 1));
                    if (idx_reg == RESP_IDX_W'(RESP_LEN - 1)) begin
                        state_next = B_IDLE;
                    end else begin
                        idx_next = idx_reg + RESP_IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        end_reg  <= end_next;
        code_reg <= code_next;
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end
endmodule

// ----- hdl/addressed_serial_frame_receiver.sv -----
// Top level: addressed serial frame receiver with block check and error responses.
//
//  Channel | Ports              | Direction | Contents
//  --------+--------------------+-----------+-----------------------------------------
//  s_      | tvalid/tready/...  | in        | received byte or time tick
//  m_      | tvalid/tready/...  | out       | payload byte or response byte, tlast ends run
//  cfg_    | wr_en/index/wdata  | in        | register writes, no read-back
//
// Cycles: one input transaction per cycle while no frame is being collected
// behind a pending command. A released payload drains one byte at a time,
// each through B_FETCH and B_LOAD (frame buffer read is registered, then the
// output register loads); an error response is five bytes. Reset clears parser,
// queue and output sequencer state; the frame buffer is not cleared. While an
// earlier command is still executing, s_tready drops only once the next frame
// reaches its data bytes, since those overwrite the frame buffer.
module addressed_serial_frame_receiver #(
    parameter int FRAME_DEPTH = asfr_pkg::DEFAULT_FRAME_DEPTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] rx_byte
    input  logic                               s_tuser,   // [0] opcode
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] out_byte
    output logic                               m_tuser,   // [0] out_kind
    output logic                               m_tlast,   // out_last
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [asfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [asfr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import asfr_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_DEPTH);

    cfg_t              cfg_reg;
    cmd_t              push_data, pop_data;
    logic              push, pop, q_full, q_empty;
    logic              back_state_busy;
    logic              ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
    logic [7:0]        ram_wr_data, ram_rd_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RX_START:   cfg_reg.rx_start_byte <= cfg_wdata[7:0];
                REG_RX_END:     cfg_reg.rx_end_byte   <= cfg_wdata[7:0];
                REG_TX_START:   cfg_reg.tx_start_byte <= cfg_wdata[7:0];
                REG_TX_END:     cfg_reg.tx_end_byte   <= cfg_wdata[7:0];
                REG_OWN_ADDR:   cfg_reg.own_address   <= cfg_wdata[7:0];
                REG_CHECK_MODE: cfg_reg.check_mode    <= cfg_wdata[0];
                REG_TIMEOUT:    cfg_reg.timeout_ticks <= cfg_wdata[7:0];
                REG_ERR_CODES:  cfg_reg.error_codes   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front end: parses transactions, writes frame buffer, queues commands
    asfr_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser),
        .in_byte     (s_tdata),
        .back_busy   (back_state_busy || !q_empty),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .q_push      (push),
        .q_data      (push_data),
        .q_full      (q_full)
    );

    asfr_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Frame buffer
    asfr_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_frame_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Back end: output sequencer with its own output register
    asfr_back #(.FRAME_DEPTH(FRAME_DEPTH)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .q_data      (pop_data),
        .q_empty     (q_empty),
        .q_pop       (pop),
        .busy        (back_state_busy),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_byte    (m_tdata),
        .out_last    (m_tlast)
    );
endmodule

// ----- tb/tb_addressed_serial_frame_receiver.sv -----
// Self-checking testbench for the addressed serial frame receiver: scoreboard and stimulus.
module tb_addressed_serial_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import asfr_pkg::*;

    localparam int DEPTH         = DEFAULT_FRAME_DEPTH;
    localparam int SETTLE_CYCLES = 16;      // back end drain margin after the last result
    localparam int CYCLE_LIMIT   = 200000;  // watchdog, far above the slowest legal run

    // receive parser states
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ADDR,
        PH_COLLECT
    } rx_phase_t;

    // one result transaction as seen on the m_ channel
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } out_beat_t;

    // Frame scoreboard: tracks parser state and the configuration, turns every
    // accepted input transaction into the result transactions it must cause,
    // and compares arriving results against the oldest expectation.
    class frame_scoreboard;
        cfg_t        cfg;
        rx_phase_t   phase;
        logic [7:0]  store [DEPTH];
        int unsigned fill;
        logic [7:0]  run_check;     // check over stored bytes except the newest
        logic [7:0]  ticks_left;
        out_beat_t   due [$];
        int          errors;

        function new();
            errors = 0;
            cfg    = CFG_RESET;
            go_idle();
        endfunction

        function logic [7:0] fold_byte(logic [7:0] acc, logic [7:0] b);
            return (cfg.check_mode == CHECK_XOR) ? (acc ^ b) : (acc + b);
        endfunction

        function void go_idle();
            phase      = PH_IDLE;
            fill       = 0;
            run_check  = 8'h00;
            ticks_left = cfg.timeout_ticks;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_RX_START:   cfg.rx_start_byte = v[7:0];
                REG_RX_END:     cfg.rx_end_byte   = v[7:0];
                REG_TX_START:   cfg.tx_start_byte = v[7:0];
                REG_TX_END:     cfg.tx_end_byte   = v[7:0];
                REG_OWN_ADDR:   cfg.own_address   = v[7:0];
                REG_CHECK_MODE: cfg.check_mode    = v[0];
                REG_TIMEOUT:    cfg.timeout_ticks = v[7:0];
                default:        cfg.error_codes   = v;
            endcase
        endfunction

        // five-byte error frame, then back to idle
        function void push_response(logic [7:0] code);
            logic [7:0] chk;
            chk = fold_byte(fold_byte(8'h00, cfg.own_address), code);
            due.push_back('{KIND_RESPONSE, cfg.tx_start_byte, 1'b0});
            due.push_back('{KIND_RESPONSE, cfg.own_address, 1'b0});
            due.push_back('{KIND_RESPONSE, code, 1'b0});
            due.push_back('{KIND_RESPONSE, chk, 1'b0});
            due.push_back('{KIND_RESPONSE, cfg.tx_end_byte, 1'b1});
            go_idle();
        endfunction

        // check byte that would close the open frame as good
        function logic [7:0] check_due();
            return (fill == 0) ? 8'h00 : fold_byte(run_check, store[fill-1]);
        endfunction

        function void note_item(logic op, logic [7:0] b);
            int unsigned i;
            if (op == OP_TICK) begin
                if (phase != PH_IDLE) begin
                    if (ticks_left <= 8'd1)
                        go_idle();
                    else
                        ticks_left--;
                end
                return;
            end
            case (phase)
                PH_IDLE: begin
                    if (b == cfg.rx_start_byte) begin
                        phase      = PH_ADDR;
                        fill       = 0;
                        run_check  = 8'h00;
                        ticks_left = cfg.timeout_ticks;
                    end
                end
                PH_ADDR: begin
                    // a wrong address drops the frame; it is not re-examined as a start
                    if (b != cfg.own_address) begin
                        go_idle();
                    end else begin
                        store[0]  = b;
                        fill      = 1;
                        run_check = 8'h00;
                        phase     = PH_COLLECT;
                    end
                end
                default: begin
                    if (b == cfg.rx_end_byte) begin
                        if (store[0] != cfg.own_address) begin
                            go_idle();
                        end else if (store[fill-1] != run_check) begin
                            push_response(cfg.error_codes[7:0]);
                        end else begin
                            for (i = 1; i + 1 < fill; i++)
                                due.push_back('{KIND_PAYLOAD, store[i], (i + 2 == fill)});
                            go_idle();
                        end
                    end else begin
                        run_check   = fold_byte(run_check, store[fill-1]);
                        store[fill] = b;
                        fill++;
                        if (fill >= DEPTH)
                            push_response(cfg.error_codes[15:8]);
                    end
                end
            endcase
        endfunction

        function void check_result(logic kind, logic [7:0] data, logic last);
            out_beat_t want;
            if (due.size() == 0) begin
                $display("%0t: unexpected result, none pending: kind %0d byte %02h last %0d",
                         $time, kind, data, last);
                errors++;
                return;
            end
            want = due.pop_front();
            if (want.kind !== kind) begin
                $display("%0t: out_kind expected %0d actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (want.data !== data) begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
                errors++;
            end
            if (want.last !== last) begin
                $display("%0t: out_last expected %0d actual %0d", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    // clock, reset and DUT ports; every input starts at a known value
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = 8'h00;   // [7:0] rx_byte
    logic                   s_tuser   = OP_BYTE; // [0] opcode
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [7:0]             m_tdata;             // [7:0] out_byte
    logic                   m_tuser;             // [0] out_kind
    logic                   m_tlast;             // out_last
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_RX_START;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    frame_scoreboard sb = new();
    bit              steady      = 1'b0;  // set: neither side inserts idle cycles
    int              items_sent  = 0;
    int              cycle_count = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    addressed_serial_frame_receiver i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Result side: values are sampled at the edge before any NBA lands, so a
    // transaction is exactly tvalid && tready as they stood before the edge.
    // tready is then drawn low with a probability of 16 in 100 unless steady is set.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
        m_tready <= steady || ($urandom_range(0, 99) >= 16);
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // One input transaction. Random idle cycles go in front of it; tvalid is
    // left high afterwards so back-to-back items need no extra step.
    task automatic send_item(input logic op, input logic [7:0] b);
        while (!steady && $urandom_range(0, 99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_item(op, b);
        items_sent++;
    endtask

    // Drop tvalid, wait for every pending result, then give the back end time
    // to finish anything that produced no result.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write; only called while the block is quiet
    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.write_reg(idx, v);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // random byte biased toward the extremes
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // Complete frame: start, address, payload, check byte, end. Payload avoids
    // the end byte; a few ticks are mixed in, never enough to time out.
    // corrupt flips bits of the check byte to force a checksum error.
    task automatic send_frame(input int n_payload, input bit corrupt);
        logic [7:0] b;
        int         ticks;
        int         k;
        ticks = 0;
        send_item(OP_BYTE, sb.cfg.rx_start_byte);
        send_item(OP_BYTE, sb.cfg.own_address);
        for (k = 0; k < n_payload; k++) begin
            do
                b = 8'($urandom);
            while (b == sb.cfg.rx_end_byte);
            send_item(OP_BYTE, b);
            if ($urandom_range(0, 9) == 0 && ticks + 2 < int'(sb.cfg.timeout_ticks)) begin
                send_item(OP_TICK, 8'($urandom));
                ticks++;
            end
        end
        b = sb.check_due();
        if (corrupt)
            b = b ^ 8'($urandom_range(1, 255));
        send_item(OP_BYTE, b);
        send_item(OP_BYTE, sb.cfg.rx_end_byte);
    endtask

    // every register gets a fresh value
    task automatic random_config();
        cfg_write(REG_RX_START, pick_byte());
        cfg_write(REG_RX_END, pick_byte());
        cfg_write(REG_TX_START, pick_byte());
        cfg_write(REG_TX_END, pick_byte());
        cfg_write(REG_OWN_ADDR, pick_byte());
        cfg_write(REG_CHECK_MODE, CFG_DATA_W'($urandom_range(0, 1)));
        cfg_write(REG_TIMEOUT, CFG_DATA_W'($urandom_range(1, 12)));
        cfg_write(REG_ERR_CODES, {pick_byte(), pick_byte()});
    endtask

    // Mostly well-formed frames with random content; the rest are checksum
    // errors, wrong addresses, timeouts, overruns, frames left open and noise.
    // with_long starts with an overrun and the longest good frame.
    task automatic random_traffic(input int quota, input bit with_long);
        int         base;
        int         frames;
        int         r;
        int         k;
        logic [7:0] b;
        base   = items_sent;
        frames = 0;
        while (items_sent - base < quota) begin
            r = $urandom_range(0, 99);
            if (with_long && frames == 0) begin
                send_frame(DEPTH - 2, 1'b0);
            end else if (with_long && frames == 1) begin
                send_frame(DEPTH - 3, 1'b0);
            end else if (r < 55) begin
                send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(9, DEPTH - 3)
                                                       : $urandom_range(0, 8), 1'b0);
            end else if (r < 67) begin
                send_frame($urandom_range(0, 6), 1'b1);
            end else if (r < 73) begin
                // wrong address
                send_item(OP_BYTE, sb.cfg.rx_start_byte);
                do
                    b = 8'($urandom);
                while (b == sb.cfg.own_address);
                send_item(OP_BYTE, b);
            end else if (r < 80) begin
                // frame abandoned by ticks
                send_item(OP_BYTE, sb.cfg.rx_start_byte);
                send_item(OP_BYTE, sb.cfg.own_address);
                for (k = $urandom_range(0, 3); k > 0; k--)
                    send_item(OP_BYTE, 8'($urandom));
                for (k = int'(sb.cfg.timeout_ticks); k > 0; k--)
                    send_item(OP_TICK, 8'($urandom));
            end else if (r < 86) begin
                send_frame(DEPTH - 2, 1'b0);
            end else if (r < 92) begin
                // frame left open; the next start byte lands in it as data
                send_item(OP_BYTE, sb.cfg.rx_start_byte);
                send_item(OP_BYTE, sb.cfg.own_address);
                for (k = $urandom_range(1, 3); k > 0; k--)
                    send_item(OP_BYTE, 8'($urandom));
            end else begin
                for (k = $urandom_range(1, 4); k > 0; k--)
                    send_item(1'($urandom_range(0, 1)), 8'($urandom));
            end
            frames++;
        end
    endtask

    initial begin
        int ph;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed, reset settings ----
        send_item(OP_TICK, 8'hFF);               // tick while idle is ignored
        send_frame(1, 1'b0);                     // one payload byte
        send_frame(0, 1'b0);                     // empty payload, no results
        send_item(OP_BYTE, sb.cfg.rx_start_byte); // address only: check of nothing is 0
        send_item(OP_BYTE, sb.cfg.own_address);
        send_item(OP_BYTE, sb.cfg.rx_end_byte);
        send_frame(2, 1'b1);                     // checksum error response
        send_item(OP_BYTE, sb.cfg.rx_start_byte); // wrong address equal to the start
        send_item(OP_BYTE, sb.cfg.rx_start_byte); // byte: dropped, not a new start
        send_item(OP_BYTE, sb.cfg.own_address);
        settle();

        // ---- low extremes, XOR check, shortest timeout ----
        cfg_write(REG_OWN_ADDR, 16'h0000);
        cfg_write(REG_RX_START, 16'h0000);
        cfg_write(REG_RX_END, 16'h00FF);
        cfg_write(REG_TX_START, 16'h00FF);
        cfg_write(REG_TX_END, 16'h0000);
        cfg_write(REG_CHECK_MODE, CFG_DATA_W'(CHECK_XOR));
        cfg_write(REG_TIMEOUT, 16'h0001);
        cfg_write(REG_ERR_CODES, 16'hFFFF);
        send_item(OP_BYTE, sb.cfg.rx_start_byte); // address 0 alone matches an empty check
        send_item(OP_BYTE, sb.cfg.own_address);
        send_item(OP_BYTE, sb.cfg.rx_end_byte);
        send_item(OP_BYTE, sb.cfg.rx_start_byte); // first tick times out
        send_item(OP_BYTE, sb.cfg.own_address);
        send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, sb.cfg.rx_start_byte); // start byte inside a frame is data
        send_item(OP_BYTE, sb.cfg.own_address);
        send_item(OP_BYTE, sb.cfg.rx_start_byte);
        send_item(OP_BYTE, sb.check_due());
        send_item(OP_BYTE, sb.cfg.rx_end_byte);
        send_frame(3, 1'b1);
        // check mode switched while a frame is open
        send_item(OP_BYTE, sb.cfg.rx_start_byte);
        send_item(OP_BYTE, sb.cfg.own_address);
        send_item(OP_BYTE, 8'h5A);
        settle();
        cfg_write(REG_CHECK_MODE, CFG_DATA_W'(CHECK_SUM));
        send_item(OP_BYTE, 8'hA5);
        send_item(OP_BYTE, sb.check_due());
        send_item(OP_BYTE, sb.cfg.rx_end_byte);
        settle();

        // ---- zero timeout acts like one; address changed while a frame is open ----
        cfg_write(REG_TIMEOUT, 16'h0000);
        send_item(OP_BYTE, sb.cfg.rx_start_byte);
        send_item(OP_BYTE, sb.cfg.own_address);
        send_item(OP_BYTE, 8'h11);
        settle();
        cfg_write(REG_OWN_ADDR, 16'h0080);
        send_item(OP_BYTE, sb.cfg.rx_end_byte);  // stored address is stale: dropped
        send_item(OP_BYTE, sb.cfg.rx_start_byte);
        send_item(OP_BYTE, sb.cfg.own_address);
        send_item(OP_TICK, 8'hFF);
        send_frame(2, 1'b0);
        settle();

        // ---- high extremes, start byte equals end byte, longest timeout ----
        cfg_write(REG_OWN_ADDR, 16'h00FF);
        cfg_write(REG_RX_START, 16'h0055);
        cfg_write(REG_RX_END, 16'h0055);
        cfg_write(REG_TX_START, 16'h0000);
        cfg_write(REG_TX_END, 16'h00FF);
        cfg_write(REG_TIMEOUT, 16'h00FF);
        cfg_write(REG_ERR_CODES, 16'h0000);
        send_item(OP_BYTE, sb.cfg.rx_start_byte); // end tested first: address-only frame,
        send_item(OP_BYTE, sb.cfg.own_address);   // 0xFF against empty check -> error
        send_item(OP_BYTE, sb.cfg.rx_end_byte);
        send_item(OP_BYTE, sb.cfg.rx_start_byte); // many ticks, still inside the budget
        send_item(OP_BYTE, sb.cfg.own_address);
        repeat (8) send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, sb.check_due());
        send_item(OP_BYTE, sb.cfg.rx_end_byte);
        send_frame(4, 1'b0);
        settle();

        // ---- random phases; the second runs without idle cycles on either side ----
        for (ph = 0; ph < 2; ph++) begin
            random_config();
            steady = (ph == 1);
            random_traffic(15, ph == 0);
            settle();
        end
        steady = 1'b0;
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- addressed_serial_frame_receiver.f -----
hdl/asfr_pkg.sv
hdl/asfr_ram.sv
hdl/asfr_cmd_fifo.sv
hdl/asfr_front.sv
hdl/asfr_back.sv
hdl/addressed_serial_frame_receiver.sv
tb/tb_addressed_serial_frame_receiver.sv
